>>> design/text_to_integer_parser_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the parser RTL
// Each macro samples on clock and is switched off while reset is high.
// ---------------------------------------------------------------------------
`ifndef TEXT_TO_INTEGER_PARSER_CORE_ASSERT_SVH
`define TEXT_TO_INTEGER_PARSER_CORE_ASSERT_SVH

// Condition holds at every edge
`define TTIP_ASSERT_HOLDS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define TTIP_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the next cycle
`define TTIP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/ttip_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ttip_pkg
// Types, codes and constants of the text-to-integer parser.
// ---------------------------------------------------------------------------
package ttip_pkg;

   // Value range of the accumulator (signed range of VALUE_BITS bits)
   localparam int VALUE_BITS = 64;
   localparam int ACC_W      = VALUE_BITS + 5;
   localparam logic [VALUE_BITS-1:0] RANGE_LIMIT = {1'b1, {(VALUE_BITS-1){1'b0}}};

   localparam int NUMBER_W = 64;
   localparam int BASE_W   = 5;
   localparam int STATUS_W = 2;
   localparam int CHAR_W   = 8;

   localparam logic [BASE_W-1:0] BASE_NONE = 5'd0;
   localparam logic [BASE_W-1:0] BASE_BIN  = 5'd2;
   localparam logic [BASE_W-1:0] BASE_OCT  = 5'd8;
   localparam logic [BASE_W-1:0] BASE_DEC  = 5'd10;
   localparam logic [BASE_W-1:0] BASE_HEX  = 5'd16;
   localparam logic [BASE_W-1:0] NO_DIGIT  = 5'd31;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISSING  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_BASE = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_INVALID  = 2'd3;

   // Queue between classifier and executor
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_FORCED_BASE = 1'b0;

   typedef enum logic [2:0] {
      CLS_NONE,
      CLS_WS,
      CLS_UNDER,
      CLS_PLUS,
      CLS_MINUS,
      CLS_OTHER
   } char_class_type;

   typedef struct packed {
      logic              has_char;
      logic [CHAR_W-1:0] char_code;
      logic              last;
   } req_payload_type;

   typedef struct packed {
      logic signed [NUMBER_W-1:0] number;
      logic [BASE_W-1:0]          base_used;
      logic [STATUS_W-1:0]        status;
   } rsp_payload_type;

   typedef struct packed {
      char_class_type    cls;
      logic              is_zero;
      logic [BASE_W-1:0] digit;
      logic [BASE_W-1:0] prefix_base;
      logic              last;
   } ttip_item_type;

endpackage

>>> design/ttip_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ttip_front
// Accepts characters and classifies them into queue entries.
// ---------------------------------------------------------------------------
module ttip_front import ttip_pkg::*; (
   input  logic            req_valid,
   input  req_payload_type req_payload,
   output logic            req_ready,
   input  logic            q_full,
   output logic            q_push,
   output ttip_item_type   q_item
);

   function automatic logic [BASE_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
      logic [BASE_W-1:0] d;
      d = NO_DIGIT;
      if (c >= "0" && c <= "9") d = BASE_W'(c - "0");
      else if (c >= "a" && c <= "f") d = BASE_W'(c - "a" + 8'd10);
      else if (c >= "A" && c <= "F") d = BASE_W'(c - "A" + 8'd10);
      return d;
   endfunction

   function automatic logic [BASE_W-1:0] prefix_base(input logic [CHAR_W-1:0] c);
      logic [BASE_W-1:0] b;
      b = BASE_NONE;
      if (c == "x" || c == "X") b = BASE_HEX;
      else if (c == "b" || c == "B") b = BASE_BIN;
      else if (c == "o" || c == "O") b = BASE_OCT;
      return b;
   endfunction

   logic [CHAR_W-1:0] c;

   assign c         = req_payload.char_code;
   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_item.last        = req_payload.last;
      q_item.is_zero     = (c == "0");
      q_item.digit       = digit_value(c);
      q_item.prefix_base = prefix_base(c);
      // spaces and empty items leave the state alone
      if (!req_payload.has_char || c == " ") q_item.cls = CLS_NONE;
      else if (c >= 8'd9 && c <= 8'd13) q_item.cls = CLS_WS;
      else if (c == "_") q_item.cls = CLS_UNDER;
      else if (c == "+") q_item.cls = CLS_PLUS;
      else if (c == "-") q_item.cls = CLS_MINUS;
      else q_item.cls = CLS_OTHER;
   end

endmodule

>>> design/ttip_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ttip_queue
// Short FIFO of classified characters between front and back.
// ---------------------------------------------------------------------------
module ttip_queue import ttip_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  ttip_item_type push_item,
   output logic          full,
   input  logic          pop,
   output ttip_item_type pop_item,
   output logic          not_empty
);

   ttip_item_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]    count_ff, count_in;

   assign full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) entry_ff[wr_ptr_ff] <= push_item;
   end

endmodule

>>> design/ttip_exec.sv
`timescale 1ns / 1ps
`include "text_to_integer_parser_core_assert.svh"
// ---------------------------------------------------------------------------
// ttip_exec
// Parse state machine, result snapshot and output register.
// ---------------------------------------------------------------------------
module ttip_exec import ttip_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [BASE_W-1:0] forced_base,
   input  logic              q_valid,
   input  ttip_item_type     q_item,
   output logic              q_pop,
   output logic              rsp_valid,
   output rsp_payload_type   rsp_payload,
   input  logic              rsp_ready
);

   typedef enum logic [2:0] {
      PH_START,
      PH_SIGNED,
      PH_ZERO,
      PH_PREFIXED,
      PH_DIGITS,
      PH_TRAIL
   } phase_type;

   typedef struct packed {
      logic                  neg;
      logic [VALUE_BITS-1:0] mag;
      logic                  ovf;
      logic [BASE_W-1:0]     base;
      logic                  digit_seen;
      logic                  content_seen;
      logic                  bad;
   } snap_type;

   phase_type             phase_ff, phase_in, cons_phase;
   logic                  neg_ff, neg_in, cons_neg;
   logic [VALUE_BITS-1:0] mag_ff, mag_in, cons_mag;
   logic                  ovf_ff, ovf_in, cons_ovf;
   logic [BASE_W-1:0]     active_ff, active_in, cons_active;
   logic                  digit_ff, digit_in, cons_digit;
   logic                  content_ff, content_in, cons_content;
   logic                  bad_ff, bad_in, cons_bad;

   snap_type              snap_ff, snap_in;
   logic                  snap_valid_ff, snap_valid_in;
   rsp_payload_type       out_ff, out_in, fin;
   logic                  out_valid_ff, out_valid_in;

   logic [BASE_W-1:0]     eff_base, step_base;
   logic [ACC_W-1:0]      mag_ext, scaled, acc;
   logic                  out_take, snap_free, end_text;
   logic [VALUE_BITS-1:0] signed_val;
   logic                  fits, base_ok;
   logic                  state_clear, out_ok, out_failed, out_base_ok;

   assign out_take  = !out_valid_ff || rsp_ready;
   assign snap_free = !snap_valid_ff || out_take;
   assign q_pop     = q_valid && (!q_item.last || snap_free);
   assign end_text  = q_pop && q_item.last;

   assign eff_base  = (forced_base != BASE_NONE) ? forced_base : active_ff;
   assign step_base = (eff_base == BASE_NONE) ? BASE_DEC : eff_base;
   assign mag_ext   = ACC_W'(mag_ff);

   // magnitude * base + digit; unsupported bases end in a status that hides it
   always_comb begin
      case (step_base)
         BASE_BIN: scaled = mag_ext << 1;
         BASE_OCT: scaled = mag_ext << 3;
         BASE_HEX: scaled = mag_ext << 4;
         BASE_DEC: scaled = (mag_ext << 3) + (mag_ext << 1);
         default:  scaled = mag_ext << 1;
      endcase
      acc = scaled + ACC_W'(q_item.digit);
   end

   // one character against the current state
   always_comb begin
      cons_phase   = phase_ff;
      cons_neg     = neg_ff;
      cons_mag     = mag_ff;
      cons_ovf     = ovf_ff;
      cons_active  = active_ff;
      cons_digit   = digit_ff;
      cons_content = content_ff;
      cons_bad     = bad_ff;
      case (q_item.cls)
         CLS_NONE: begin
         end
         CLS_WS: begin
            if (content_ff) cons_phase = PH_TRAIL;
         end
         default: begin
            cons_content = 1'b1;
            if (phase_ff == PH_TRAIL) begin
               cons_bad = 1'b1;
            end else if (q_item.cls == CLS_UNDER) begin
               cons_bad = bad_ff;
            end else if (q_item.cls == CLS_PLUS || q_item.cls == CLS_MINUS) begin
               if (phase_ff == PH_START) begin
                  cons_neg   = (q_item.cls == CLS_MINUS);
                  cons_phase = PH_SIGNED;
               end else begin
                  cons_bad = 1'b1;
               end
            end else if (phase_ff == PH_ZERO && q_item.prefix_base != BASE_NONE &&
                         (eff_base == BASE_NONE || eff_base == q_item.prefix_base)) begin
               if (forced_base == BASE_NONE) cons_active = q_item.prefix_base;
               cons_phase = PH_PREFIXED;
               cons_digit = 1'b0;
            end else if ((phase_ff == PH_START || phase_ff == PH_SIGNED) && q_item.is_zero) begin
               cons_phase = PH_ZERO;
               cons_digit = 1'b1;
            end else begin
               if (eff_base == BASE_NONE) cons_active = BASE_DEC;
               if (q_item.digit >= step_base) begin
                  cons_bad = 1'b1;
               end else begin
                  if (acc > ACC_W'(RANGE_LIMIT)) cons_ovf = 1'b1;
                  else cons_mag = acc[VALUE_BITS-1:0];
                  cons_digit = 1'b1;
                  cons_phase = PH_DIGITS;
               end
            end
         end
      endcase
   end

   always_comb begin
      phase_in   = phase_ff;
      neg_in     = neg_ff;
      mag_in     = mag_ff;
      ovf_in     = ovf_ff;
      active_in  = active_ff;
      digit_in   = digit_ff;
      content_in = content_ff;
      bad_in     = bad_ff;
      if (end_text) begin
         phase_in   = PH_START;
         neg_in     = 1'b0;
         mag_in     = '0;
         ovf_in     = 1'b0;
         active_in  = BASE_NONE;
         digit_in   = 1'b0;
         content_in = 1'b0;
         bad_in     = 1'b0;
      end else if (q_pop) begin
         phase_in   = cons_phase;
         neg_in     = cons_neg;
         mag_in     = cons_mag;
         ovf_in     = cons_ovf;
         active_in  = cons_active;
         digit_in   = cons_digit;
         content_in = cons_content;
         bad_in     = cons_bad;
      end
   end

   // capture the finished text
   always_comb begin
      snap_in       = snap_ff;
      snap_valid_in = snap_valid_ff && !out_take;
      if (end_text) begin
         snap_valid_in        = 1'b1;
         snap_in.neg          = cons_neg;
         snap_in.mag          = cons_mag;
         snap_in.ovf          = cons_ovf;
         snap_in.digit_seen   = cons_digit;
         snap_in.content_seen = cons_content;
         snap_in.bad          = cons_bad;
         if (forced_base != BASE_NONE) snap_in.base = forced_base;
         else if (cons_active == BASE_NONE) snap_in.base = BASE_DEC;
         else snap_in.base = cons_active;
      end
   end

   // status and signed value from the snapshot
   always_comb begin
      fits       = !(snap_ff.mag == RANGE_LIMIT && !snap_ff.neg);
      base_ok    = (snap_ff.base == BASE_BIN) || (snap_ff.base == BASE_OCT) ||
                   (snap_ff.base == BASE_DEC) || (snap_ff.base == BASE_HEX);
      signed_val = snap_ff.neg ? (~snap_ff.mag + 1'b1) : snap_ff.mag;
      fin.base_used = snap_ff.base;
      fin.number    = '0;
      if (!snap_ff.content_seen) begin
         fin.status = STATUS_MISSING;
      end else if (!base_ok) begin
         fin.status = STATUS_BAD_BASE;
      end else if (snap_ff.bad || !snap_ff.digit_seen || snap_ff.ovf || !fits) begin
         fin.status = STATUS_INVALID;
      end else begin
         fin.status = STATUS_OK;
         fin.number = NUMBER_W'($signed(signed_val));
      end
      out_in       = (snap_valid_ff && out_take) ? fin : out_ff;
      out_valid_in = (snap_valid_ff && out_take) ? 1'b1 : (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_START;
         neg_ff        <= 1'b0;
         mag_ff        <= '0;
         ovf_ff        <= 1'b0;
         active_ff     <= BASE_NONE;
         digit_ff      <= 1'b0;
         content_ff    <= 1'b0;
         bad_ff        <= 1'b0;
         snap_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         neg_ff        <= neg_in;
         mag_ff        <= mag_in;
         ovf_ff        <= ovf_in;
         active_ff     <= active_in;
         digit_ff      <= digit_in;
         content_ff    <= content_in;
         bad_ff        <= bad_in;
         snap_valid_ff <= snap_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      snap_ff <= snap_in;
      out_ff  <= out_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   assign state_clear = (phase_ff == PH_START) && !content_ff && (mag_ff == '0);
   assign out_ok      = out_valid_ff && (out_ff.status == STATUS_OK);
   assign out_failed  = out_valid_ff && (out_ff.status != STATUS_OK);
   assign out_base_ok = (out_ff.base_used == BASE_BIN) || (out_ff.base_used == BASE_OCT) ||
                        (out_ff.base_used == BASE_DEC) || (out_ff.base_used == BASE_HEX);

   `TTIP_ASSERT_HOLDS(a_mag_in_range, mag_ff <= RANGE_LIMIT, "magnitude above range limit")
   `TTIP_ASSERT_NEXT(a_clear_after_last, end_text, state_clear, "state not cleared after text end")
   `TTIP_ASSERT_IMPLIES(a_ok_base, out_ok, out_base_ok, "ok result with unsupported base")
   `TTIP_ASSERT_IMPLIES(a_zero_unless_ok, out_failed, out_ff.number == '0, "nonzero failed value")

endmodule

>>> design/text_to_integer_parser_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// text_to_integer_parser_core
// Parses a character stream into a signed 64-bit value with base detection.
// ---------------------------------------------------------------------------
//  Channel   Direction  Handshake               Carries
//  req_      in         req_valid / req_ready   one character or end marker
//  rsp_      out        rsp_valid / rsp_ready   value, base and status
//  csr_      in         APB write/read          forced_base
//
//  One character per cycle while the queue has room; the executor step
//  (shift-add and range compare) sets the rate.
//  A four-entry queue lets input keep flowing while the output stalls; only an
//  end-of-text item waits for the result snapshot to free up.
//  Reset is synchronous and clears all parse state and the queue.
// ---------------------------------------------------------------------------
module text_to_integer_parser_core import ttip_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [BASE_W-1:0] forced_base_ff, forced_base_in;
   logic              csr_write;
   logic              q_push, q_full, q_pop, q_valid;
   ttip_item_type     push_item, pop_item;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      forced_base_in = forced_base_ff;
      if (csr_write && csr_paddr[2] == CSR_IDX_FORCED_BASE) begin
         forced_base_in = csr_pwdata[BASE_W-1:0];
      end
      csr_prdata = (csr_paddr[2] == CSR_IDX_FORCED_BASE) ?
                   CSR_DATA_W'(forced_base_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         forced_base_ff <= BASE_NONE;
      end else begin
         forced_base_ff <= forced_base_in;
      end
   end

   ttip_front u_front (
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .req_ready   (req_ready),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_item      (push_item)
   );

   ttip_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (pop_item),
      .not_empty (q_valid)
   );

   ttip_exec u_exec (
      .clock       (clock),
      .reset       (reset),
      .forced_base (forced_base_ff),
      .q_valid     (q_valid),
      .q_item      (pop_item),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .rsp_ready   (rsp_ready)
   );

endmodule
